// ===== rtl/zhvi_pkg.sv =====
// ============================================================================
// zhvi_pkg: shared widths, constants and types for the Zou-He velocity inlet
// Fixed-point format, derived datapath widths and the divide-by-three
// reciprocal used by the boundary reconstruction pipeline.
// ============================================================================
package zhvi_pkg;

    // Fraction bits of the signed fixed-point format (range 16 to 30)
    localparam int FRAC_BITS = 28;

    localparam int DATA_W = 32;               // distribution and result width
    localparam int VEL_W  = 29;               // inlet velocity register width

    localparam int SUM3_W = DATA_W + 2;       // sum of three distributions
    localparam int SUM_W  = DATA_W + 4;       // f0+f2+f4+2(f3+f6+f7) before clamp
    localparam int CLS_W  = DATA_W + 2;       // clamped sum, +/- 2^DATA_W
    localparam int MAG_W  = DATA_W + 1;       // magnitude of clamped sum
    localparam int QUO_W  = DATA_W + 2;       // quotient bits, one per stage
    localparam int DVS_W  = FRAC_BITS + 1;    // clamped velocity and divisor
    localparam int REM_W  = FRAC_BITS + 2;    // partial remainder
    localparam int PRD_W  = DATA_W + DVS_W;   // rho * vx
    localparam int HLF_W  = DATA_W + 2;       // f7 + h and f6 - h
    localparam int OSUM_W = DATA_W + 3;       // final sums before saturation
    localparam int CFG_W  = 32;               // width used to clamp the velocity

    // floor(x / 3) == (x * RECIP3) >> REC_SH for every DATA_W-bit x
    localparam logic [DATA_W-1:0] RECIP3 = 32'hAAAA_AAAB;
    localparam int REC_SH = DATA_W + 1;
    localparam int TRM_W  = 2 * DATA_W - REC_SH;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [VEL_W-1:0]  vel_t;

    // One restoring-division step
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] dq;
    } div_state_t;

endpackage

// ===== rtl/zou_he_velocity_inlet_d2q9_top.sv =====
// ============================================================================
// zou_he_velocity_inlet_d2q9_top: Zou-He velocity inlet, D2Q9 left wall
// Rebuilds density and the east, northeast and southeast distributions of a
// boundary node from its six known distributions and the inlet velocity.
// ============================================================================
//
// Usage:
//   Input channel: drive the six known distributions and raise start. A beat
//   is taken at every rising edge with start high and busy low. busy is held
//   low: the pipeline takes one node per cycle with no gaps.
//   Output channel: done is high for exactly one cycle with density, f_east,
//   f_northeast, f_southeast and saturated. The receiver cannot hold results
//   off and none is needed: the pipeline never stalls.
//   Configuration: cfg_we with cfg_wdata loads the inlet velocity. Write it
//   only while no beat is in flight; it is clamped to plus or minus one half
//   and the divisor 1 - vx is formed at the write.
//   Pipeline: two summing stages, a load stage, QUO_W divide stages of the
//   bit-per-stage density divider, then saturation, the rho * vx multiply,
//   magnitude, the divide-by-three multiply, sign restore and the final
//   saturating adds.
//   Throughput: one node per cycle, sustained.
//   Reset: rst_n clears every valid bit and sets the velocity to zero.
//
module zou_he_velocity_inlet_d2q9_top
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 cfg_we,
    input  zhvi_pkg::vel_t       cfg_wdata,
    input  zhvi_pkg::data_t      f_rest,
    input  zhvi_pkg::data_t      f_north,
    input  zhvi_pkg::data_t      f_west,
    input  zhvi_pkg::data_t      f_south,
    input  zhvi_pkg::data_t      f_northwest,
    input  zhvi_pkg::data_t      f_southwest,
    output logic                 done,
    output zhvi_pkg::data_t      density,
    output zhvi_pkg::data_t      f_east,
    output zhvi_pkg::data_t      f_northeast,
    output zhvi_pkg::data_t      f_southeast,
    output logic                 saturated
);
    import zhvi_pkg::*;

    localparam logic signed [SUM_W-1:0] SUM_LIM  = SUM_W'(64'd1 << DATA_W);
    localparam logic [QUO_W-1:0]        POS_LIM  = QUO_W'((64'd1 << (DATA_W - 1)) - 64'd1);
    localparam logic [QUO_W-1:0]        NEG_LIM  = QUO_W'(64'd1 << (DATA_W - 1));
    localparam logic signed [CFG_W-1:0] VEL_HALF = CFG_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [CFG_W-1:0] VEL_ONE  = CFG_W'(64'd1 << FRAC_BITS);
    localparam logic signed [OSUM_W-1:0] OUT_MAX = OSUM_W'((64'd1 << (DATA_W - 1)) - 64'd1);
    localparam logic signed [OSUM_W-1:0] OUT_MIN = -OSUM_W'(64'd1 << (DATA_W - 1));

    // Saturate a final sum to the data width
    function automatic data_t sat_val(input logic signed [OSUM_W-1:0] v);
        data_t r;
        if (v > OUT_MAX)
        begin
            r = OUT_MAX[DATA_W-1:0];
        end
        else if (v < OUT_MIN)
        begin
            r = OUT_MIN[DATA_W-1:0];
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic sat_hit(input logic signed [OSUM_W-1:0] v);
        return (v > OUT_MAX) || (v < OUT_MIN);
    endfunction

    // Shift in the next dividend bit, subtract the divisor when it fits,
    // and shift the quotient bit in where the dividend bit left
    function automatic div_state_t div_step(input div_state_t s, input logic [DVS_W-1:0] dvs);
        div_state_t       r;
        logic [REM_W-1:0] rs;
        rs = {s.rem[REM_W-2:0], s.dq[QUO_W-1]};
        if (rs >= REM_W'(dvs))
        begin
            r.rem = rs - REM_W'(dvs);
            r.dq  = {s.dq[QUO_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = rs;
            r.dq  = {s.dq[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration: clamped velocity and divisor 1 - vx
    // ------------------------------------------------------------------
    logic signed [DVS_W-1:0] vel_reg, vel_next;
    logic [DVS_W-1:0]        dvs_reg, dvs_next;
    logic signed [CFG_W-1:0] cfg_wide;
    logic signed [CFG_W-1:0] cfg_clamp;
    logic signed [CFG_W-1:0] cfg_div;

    always_comb
    begin
        cfg_wide = CFG_W'(cfg_wdata);
        if (cfg_wide > VEL_HALF)
        begin
            cfg_clamp = VEL_HALF;
        end
        else if (cfg_wide < -VEL_HALF)
        begin
            cfg_clamp = -VEL_HALF;
        end
        else
        begin
            cfg_clamp = cfg_wide;
        end
        cfg_div  = VEL_ONE - cfg_clamp;
        vel_next = cfg_we ? cfg_clamp[DVS_W-1:0] : vel_reg;
        dvs_next = cfg_we ? cfg_div[DVS_W-1:0]   : dvs_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_reg <= '0;
            dvs_reg <= VEL_ONE[DVS_W-1:0];
        end
        else
        begin
            vel_reg <= vel_next;
            dvs_reg <= dvs_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: partial sums and half difference of south and north
    // ------------------------------------------------------------------
    logic                     st1_vld_reg, st1_vld_next;
    logic signed [SUM3_W-1:0] st1_s1_reg, st1_s1_next;
    logic signed [SUM3_W-1:0] st1_s2_reg, st1_s2_next;
    data_t                    st1_h_reg, st1_h_next;
    data_t                    st1_f3_reg, st1_f6_reg, st1_f7_reg;
    logic signed [DATA_W:0]   st1_diff;
    logic [DATA_W:0]          st1_hsum;

    always_comb
    begin
        st1_vld_next = start & ~busy;
        st1_s1_next  = SUM3_W'(f_rest) + SUM3_W'(f_north) + SUM3_W'(f_south);
        st1_s2_next  = SUM3_W'(f_west) + SUM3_W'(f_northwest) + SUM3_W'(f_southwest);
        // Halve toward zero: add one to negative differences before the shift
        st1_diff     = (DATA_W + 1)'(f_south) - (DATA_W + 1)'(f_north);
        st1_hsum     = st1_diff + (DATA_W + 1)'(st1_diff[DATA_W]);
        st1_h_next   = st1_hsum[DATA_W:1];
    end

    // ------------------------------------------------------------------
    // Stage 2: weighted sum with clamp, and the f7 + h, f6 - h terms
    // ------------------------------------------------------------------
    logic                    st2_vld_reg, st2_vld_next;
    logic signed [CLS_W-1:0] st2_s_reg, st2_s_next;
    logic signed [HLF_W-1:0] st2_a_reg, st2_a_next;
    logic signed [HLF_W-1:0] st2_b_reg, st2_b_next;
    data_t                   st2_f3_reg;
    logic signed [SUM_W-1:0] st2_sum;

    always_comb
    begin
        st2_vld_next = st1_vld_reg;
        st2_sum      = SUM_W'(st1_s1_reg) + (SUM_W'(st1_s2_reg) <<< 1);
        if (st2_sum > SUM_LIM)
        begin
            st2_s_next = SUM_LIM[CLS_W-1:0];
        end
        else if (st2_sum < -SUM_LIM)
        begin
            st2_s_next = CLS_W'(-SUM_LIM);
        end
        else
        begin
            st2_s_next = st2_sum[CLS_W-1:0];
        end
        st2_a_next = HLF_W'(st1_f7_reg) + HLF_W'(st1_h_reg);
        st2_b_next = HLF_W'(st1_f6_reg) - HLF_W'(st1_h_reg);
    end

    // ------------------------------------------------------------------
    // Density divider: load stage 0, then one quotient bit per stage
    // ------------------------------------------------------------------
    logic                    dv_vld_reg [0:QUO_W];
    logic                    dv_vld_next [0:QUO_W];
    div_state_t              dv_st_reg [0:QUO_W];
    div_state_t              dv_st_next [0:QUO_W];
    logic                    dv_neg_reg [0:QUO_W];
    logic                    dv_neg_next [0:QUO_W];
    data_t                   dv_f3_reg [0:QUO_W];
    data_t                   dv_f3_next [0:QUO_W];
    logic signed [HLF_W-1:0] dv_a_reg [0:QUO_W];
    logic signed [HLF_W-1:0] dv_a_next [0:QUO_W];
    logic signed [HLF_W-1:0] dv_b_reg [0:QUO_W];
    logic signed [HLF_W-1:0] dv_b_next [0:QUO_W];
    logic [CLS_W-1:0]        ld_abs;
    logic [MAG_W+FRAC_BITS-1:0] ld_num;

    always_comb
    begin
        // Work on the magnitude of S * 2^FRAC_BITS; sign is restored after
        ld_abs        = st2_s_reg[CLS_W-1] ? CLS_W'(-st2_s_reg) : CLS_W'(st2_s_reg);
        ld_num        = {ld_abs[MAG_W-1:0], {FRAC_BITS{1'b0}}};
        dv_vld_next[0] = st2_vld_reg;
        dv_neg_next[0] = st2_s_reg[CLS_W-1];
        dv_st_next[0].rem = REM_W'(ld_num[MAG_W+FRAC_BITS-1:QUO_W]);
        dv_st_next[0].dq  = ld_num[QUO_W-1:0];
        dv_f3_next[0]  = st2_f3_reg;
        dv_a_next[0]   = st2_a_reg;
        dv_b_next[0]   = st2_b_reg;
        for (int k = 0; k < QUO_W; k++)
        begin
            dv_vld_next[k+1] = dv_vld_reg[k];
            dv_st_next[k+1]  = div_step(dv_st_reg[k], dvs_reg);
            dv_neg_next[k+1] = dv_neg_reg[k];
            dv_f3_next[k+1]  = dv_f3_reg[k];
            dv_a_next[k+1]   = dv_a_reg[k];
            dv_b_next[k+1]   = dv_b_reg[k];
        end
    end

    // ------------------------------------------------------------------
    // Post 1: signed, saturated density
    // ------------------------------------------------------------------
    logic                    r1_vld_reg, r1_vld_next;
    data_t                   r1_rho_reg, r1_rho_next;
    logic                    r1_sat_reg, r1_sat_next;
    data_t                   r1_f3_reg;
    logic signed [HLF_W-1:0] r1_a_reg, r1_b_reg;
    logic [QUO_W-1:0]        r1_q;

    always_comb
    begin
        r1_vld_next = dv_vld_reg[QUO_W];
        r1_q        = dv_st_reg[QUO_W].dq;
        if (dv_neg_reg[QUO_W])
        begin
            r1_sat_next = r1_q > NEG_LIM;
            r1_rho_next = r1_sat_next ? NEG_LIM[DATA_W-1:0] : -r1_q[DATA_W-1:0];
        end
        else
        begin
            r1_sat_next = r1_q > POS_LIM;
            r1_rho_next = r1_sat_next ? POS_LIM[DATA_W-1:0] : r1_q[DATA_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Post 2: p = rho * vx
    // ------------------------------------------------------------------
    logic                    r2_vld_reg, r2_vld_next;
    logic signed [PRD_W-1:0] r2_p_reg, r2_p_next;
    logic                    r2_sat_reg;
    data_t                   r2_f3_reg;
    logic signed [HLF_W-1:0] r2_a_reg, r2_b_reg;

    always_comb
    begin
        r2_vld_next = r1_vld_reg;
        r2_p_next   = r1_rho_reg * vel_reg;
    end

    // ------------------------------------------------------------------
    // Post 3: magnitude of p, pre-shifted for the 2/3 and 1/6 terms
    // ------------------------------------------------------------------
    logic                    r3_vld_reg, r3_vld_next;
    logic [DATA_W-1:0]       r3_x3_reg, r3_x3_next;
    logic [DATA_W-1:0]       r3_x6_reg, r3_x6_next;
    logic                    r3_neg_reg, r3_neg_next;
    logic                    r3_sat_reg;
    data_t                   r3_f3_reg;
    logic signed [HLF_W-1:0] r3_a_reg, r3_b_reg;
    logic [PRD_W-1:0]        r3_pabs;

    always_comb
    begin
        r3_vld_next = r2_vld_reg;
        r3_neg_next = r2_p_reg[PRD_W-1];
        r3_pabs     = r2_p_reg[PRD_W-1] ? PRD_W'(-r2_p_reg) : PRD_W'(r2_p_reg);
        // 2p / (3 * 2^F) = (|p| >> (F-1)) / 3 and p / (6 * 2^F) = (|p| >> (F+1)) / 3
        r3_x3_next  = r3_pabs[FRAC_BITS-1 +: DATA_W];
        r3_x6_next  = r3_pabs[FRAC_BITS+1 +: DATA_W];
    end

    // ------------------------------------------------------------------
    // Post 4: divide by three through the reciprocal
    // ------------------------------------------------------------------
    logic                    r4_vld_reg, r4_vld_next;
    logic [2*DATA_W-1:0]     r4_m3_reg, r4_m3_next;
    logic [2*DATA_W-1:0]     r4_m6_reg, r4_m6_next;
    logic                    r4_neg_reg;
    logic                    r4_sat_reg;
    data_t                   r4_f3_reg;
    logic signed [HLF_W-1:0] r4_a_reg, r4_b_reg;

    always_comb
    begin
        r4_vld_next = r3_vld_reg;
        r4_m3_next  = r3_x3_reg * RECIP3;
        r4_m6_next  = r3_x6_reg * RECIP3;
    end

    // ------------------------------------------------------------------
    // Post 5: restore the sign of both velocity terms
    // ------------------------------------------------------------------
    logic                    r5_vld_reg, r5_vld_next;
    data_t                   r5_te_reg, r5_te_next;
    data_t                   r5_t6_reg, r5_t6_next;
    logic                    r5_sat_reg;
    data_t                   r5_f3_reg;
    logic signed [HLF_W-1:0] r5_a_reg, r5_b_reg;
    logic [DATA_W-1:0]       r5_te_mag;
    logic [DATA_W-1:0]       r5_t6_mag;

    always_comb
    begin
        r5_vld_next = r4_vld_reg;
        r5_te_mag   = DATA_W'(r4_m3_reg[2*DATA_W-1:REC_SH]);
        r5_t6_mag   = DATA_W'(r4_m6_reg[2*DATA_W-1:REC_SH]);
        r5_te_next  = r4_neg_reg ? -r5_te_mag : r5_te_mag;
        r5_t6_next  = r4_neg_reg ? -r5_t6_mag : r5_t6_mag;
    end

    // ------------------------------------------------------------------
    // Post 6: final sums, saturation and the result registers
    // ------------------------------------------------------------------
    logic                     out_vld_reg, out_vld_next;
    data_t                    density_reg, density_next;
    data_t                    east_reg, east_next;
    data_t                    neast_reg, neast_next;
    data_t                    seast_reg, seast_next;
    logic                     sat_reg, sat_next;
    logic signed [OSUM_W-1:0] o_east;
    logic signed [OSUM_W-1:0] o_ne;
    logic signed [OSUM_W-1:0] o_se;
    data_t                    r5_rho_reg;

    always_comb
    begin
        out_vld_next = r5_vld_reg;
        o_east       = OSUM_W'(r5_f3_reg) + OSUM_W'(r5_te_reg);
        o_ne         = OSUM_W'(r5_a_reg) + OSUM_W'(r5_t6_reg);
        o_se         = OSUM_W'(r5_b_reg) + OSUM_W'(r5_t6_reg);
        density_next = r5_rho_reg;
        east_next    = sat_val(o_east);
        neast_next   = sat_val(o_ne);
        seast_next   = sat_val(o_se);
        sat_next     = r5_sat_reg | sat_hit(o_east) | sat_hit(o_ne) | sat_hit(o_se);
    end

    // Density rides along from post 1 to the result registers
    data_t r2_rho_reg, r3_rho_reg, r4_rho_reg;

    // ------------------------------------------------------------------
    // Valid bits: cleared by reset
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_vld_reg <= 1'b0;
            st2_vld_reg <= 1'b0;
            for (int k = 0; k <= QUO_W; k++)
            begin
                dv_vld_reg[k] <= 1'b0;
            end
            r1_vld_reg  <= 1'b0;
            r2_vld_reg  <= 1'b0;
            r3_vld_reg  <= 1'b0;
            r4_vld_reg  <= 1'b0;
            r5_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            st1_vld_reg <= st1_vld_next;
            st2_vld_reg <= st2_vld_next;
            for (int k = 0; k <= QUO_W; k++)
            begin
                dv_vld_reg[k] <= dv_vld_next[k];
            end
            r1_vld_reg  <= r1_vld_next;
            r2_vld_reg  <= r2_vld_next;
            r3_vld_reg  <= r3_vld_next;
            r4_vld_reg  <= r4_vld_next;
            r5_vld_reg  <= r5_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload: advance every cycle, no reset
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        st1_s1_reg <= st1_s1_next;
        st1_s2_reg <= st1_s2_next;
        st1_h_reg  <= st1_h_next;
        st1_f3_reg <= f_west;
        st1_f6_reg <= f_northwest;
        st1_f7_reg <= f_southwest;

        st2_s_reg  <= st2_s_next;
        st2_a_reg  <= st2_a_next;
        st2_b_reg  <= st2_b_next;
        st2_f3_reg <= st1_f3_reg;

        for (int k = 0; k <= QUO_W; k++)
        begin
            dv_st_reg[k]  <= dv_st_next[k];
            dv_neg_reg[k] <= dv_neg_next[k];
            dv_f3_reg[k]  <= dv_f3_next[k];
            dv_a_reg[k]   <= dv_a_next[k];
            dv_b_reg[k]   <= dv_b_next[k];
        end

        r1_rho_reg <= r1_rho_next;
        r1_sat_reg <= r1_sat_next;
        r1_f3_reg  <= dv_f3_reg[QUO_W];
        r1_a_reg   <= dv_a_reg[QUO_W];
        r1_b_reg   <= dv_b_reg[QUO_W];

        r2_p_reg   <= r2_p_next;
        r2_rho_reg <= r1_rho_reg;
        r2_sat_reg <= r1_sat_reg;
        r2_f3_reg  <= r1_f3_reg;
        r2_a_reg   <= r1_a_reg;
        r2_b_reg   <= r1_b_reg;

        r3_x3_reg  <= r3_x3_next;
        r3_x6_reg  <= r3_x6_next;
        r3_neg_reg <= r3_neg_next;
        r3_rho_reg <= r2_rho_reg;
        r3_sat_reg <= r2_sat_reg;
        r3_f3_reg  <= r2_f3_reg;
        r3_a_reg   <= r2_a_reg;
        r3_b_reg   <= r2_b_reg;

        r4_m3_reg  <= r4_m3_next;
        r4_m6_reg  <= r4_m6_next;
        r4_neg_reg <= r3_neg_reg;
        r4_rho_reg <= r3_rho_reg;
        r4_sat_reg <= r3_sat_reg;
        r4_f3_reg  <= r3_f3_reg;
        r4_a_reg   <= r3_a_reg;
        r4_b_reg   <= r3_b_reg;

        r5_te_reg  <= r5_te_next;
        r5_t6_reg  <= r5_t6_next;
        r5_rho_reg <= r4_rho_reg;
        r5_sat_reg <= r4_sat_reg;
        r5_f3_reg  <= r4_f3_reg;
        r5_a_reg   <= r4_a_reg;
        r5_b_reg   <= r4_b_reg;

        density_reg <= density_next;
        east_reg    <= east_next;
        neast_reg   <= neast_next;
        seast_reg   <= seast_next;
        sat_reg     <= sat_next;
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    // Every stage advances each cycle, so a new beat is always taken
    assign busy        = 1'b0;
    assign done        = out_vld_reg;
    assign density     = density_reg;
    assign f_east      = east_reg;
    assign f_northeast = neast_reg;
    assign f_southeast = seast_reg;
    assign saturated   = sat_reg;

endmodule
